FILE: rtl/rdq_pkg.sv
package rdq_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DUMP       = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KIND_RECORD     = 2'd0,
    KIND_DUMP_EMPTY = 2'd1,
    KIND_POP_EMPTY  = 2'd2,
    KIND_PUSH_FULL  = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

endpackage

FILE: rtl/record_deque_with_dump_top.sv
// Double-ended queue of DEPTH (id, score) records held in a ring memory with a
// registered read. A transaction is accepted when start_i is high and busy_o is
// low. Pushes and pops take effect on acceptance and the next transaction can
// follow immediately. Errors (pop on empty, push on full, dump on empty) produce
// one result on strobe_o in the cycle after acceptance. A dump reads one ring
// entry per cycle, so it holds busy_o high until every held record is read. Its
// results appear one per cycle, front to back, each from the registered memory
// read after ST_DUMP is entered, with last_o on the final one, which comes in the
// same cycle in which busy_o falls. Results cannot be stalled and must be taken
// in the cycle in which strobe_o is high.
module record_deque_with_dump_top #(
  parameter int DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] rec_id_i,
  input  logic [31:0] rec_score_i,
  output logic        strobe_o,
  output logic [1:0]  kind_o,
  output logic [31:0] out_id_o,
  output logic [31:0] out_score_o,
  output logic        last_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = PW + 1;

  logic [63:0] mem [DEPTH];

  rdq_pkg::state_e state_q, state_d;
  logic [PW-1:0]   front_q, front_d;
  logic [CW-1:0]   count_q, count_d;
  logic [PW-1:0]   rd_addr_q, rd_addr_d;
  logic [PW-1:0]   off_q, off_d;
  logic            strobe_q, strobe_d;
  rdq_pkg::kind_e  kind_q, kind_d;
  logic            last_q, last_d;
  logic [63:0]     rd_q;

  logic            accept;
  logic            wr_en;
  logic [PW-1:0]   wr_addr;
  logic [PW-1:0]   front_dec;
  logic [PW-1:0]   front_inc;
  logic [SW-1:0]   back_sum;
  logic [PW-1:0]   back_slot;
  logic            full;
  logic            empty;
  logic            dump_last;

  assign accept    = start_i && !busy_o;
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
  assign front_inc = (front_q == PW'(DEPTH - 1)) ? '0 : front_q + PW'(1);
  assign back_sum  = SW'(front_q) + SW'(count_q);
  assign back_slot = (back_sum >= SW'(DEPTH)) ? PW'(back_sum - SW'(DEPTH)) : PW'(back_sum);
  assign dump_last = (CW'(off_q) + CW'(1) == count_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rdq_pkg::ST_IDLE: begin
        if (accept && rdq_pkg::action_e'(action_i) == rdq_pkg::ACT_DUMP && !empty) begin
          state_d = rdq_pkg::ST_DUMP;
        end
      end
      rdq_pkg::ST_DUMP: begin
        if (dump_last) begin
          state_d = rdq_pkg::ST_IDLE;
        end
      end
      default: state_d = rdq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q == rdq_pkg::ST_DUMP);
  end

  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    rd_addr_d = rd_addr_q;
    off_d     = off_q;
    strobe_d  = 1'b0;
    kind_d    = kind_q;
    last_d    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = back_slot;
    if (state_q == rdq_pkg::ST_DUMP) begin
      strobe_d  = 1'b1;
      kind_d    = rdq_pkg::KIND_RECORD;
      last_d    = dump_last;
      off_d     = off_q + PW'(1);
      rd_addr_d = (rd_addr_q == PW'(DEPTH - 1)) ? '0 : rd_addr_q + PW'(1);
    end else if (accept) begin
      unique case (rdq_pkg::action_e'(action_i))
        rdq_pkg::ACT_PUSH_FRONT, rdq_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            strobe_d = 1'b1;
            kind_d   = rdq_pkg::KIND_PUSH_FULL;
            last_d   = 1'b1;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
            if (rdq_pkg::action_e'(action_i) == rdq_pkg::ACT_PUSH_FRONT) begin
              front_d = front_dec;
              wr_addr = front_dec;
            end
          end
        end
        rdq_pkg::ACT_POP_FRONT, rdq_pkg::ACT_POP_BACK: begin
          if (empty) begin
            strobe_d = 1'b1;
            kind_d   = rdq_pkg::KIND_POP_EMPTY;
            last_d   = 1'b1;
          end else begin
            count_d = count_q - CW'(1);
            if (rdq_pkg::action_e'(action_i) == rdq_pkg::ACT_POP_FRONT) begin
              front_d = front_inc;
            end
          end
        end
        rdq_pkg::ACT_DUMP: begin
          if (empty) begin
            strobe_d = 1'b1;
            kind_d   = rdq_pkg::KIND_DUMP_EMPTY;
            last_d   = 1'b1;
          end else begin
            rd_addr_d = front_q;
            off_d     = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rdq_pkg::ST_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      rd_addr_q <= '0;
      off_q     <= '0;
      strobe_q  <= 1'b0;
      kind_q    <= rdq_pkg::KIND_RECORD;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      rd_addr_q <= rd_addr_d;
      off_q     <= off_d;
      strobe_q  <= strobe_d;
      kind_q    <= kind_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {rec_id_i, rec_score_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rdq_pkg::ST_DUMP) begin
      rd_q <= mem[rd_addr_q];
    end
  end

  assign strobe_o    = strobe_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;
  assign out_id_o    = (kind_q == rdq_pkg::KIND_RECORD) ? rd_q[63:32] : '0;
  assign out_score_o = (kind_q == rdq_pkg::KIND_RECORD) ? rd_q[31:0] : '0;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_record_from_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && kind_o == rdq_pkg::KIND_RECORD |-> $past(state_q == rdq_pkg::ST_DUMP))
    else $error("record result outside a dump");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && kind_o != rdq_pkg::KIND_RECORD |-> last_o)
    else $error("single result without last marker");

  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rdq_pkg::ST_DUMP && dump_last |=> state_q == rdq_pkg::ST_IDLE && last_o)
    else $error("dump did not end with last marker");

endmodule

FILE: tb/sv/tb_record_deque_with_dump_top.sv
`timescale 1ns / 100ps

module tb_record_deque_with_dump_top;

  localparam int DEPTH = 32;
  localparam int RANDOM_ITEMS = 160;
  localparam int WATCHDOG_LIMIT = 200;
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  typedef struct {
    rdq_pkg::kind_e kind;
    logic [31:0]    id;
    logic [31:0]    score;
    logic           last;
  } result_t;

  typedef struct {
    logic [2:0]     act;
    logic [31:0]    id;
    logic [31:0]    score;
    bit             typed;
    rdq_pkg::kind_e kind;
  } row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start_i = 1'b0;
  logic [2:0]     action_i = '0;
  logic [31:0]    rec_id_i = '0;
  logic [31:0]    rec_score_i = '0;
  bit             row_typed = 1'b0;
  rdq_pkg::kind_e row_kind = rdq_pkg::KIND_RECORD;
  logic           busy_o;
  logic           strobe_o;
  logic [1:0]     kind_o;
  logic [31:0]    out_id_o;
  logic [31:0]    out_score_o;
  logic           last_o;

  always #6 clk_i = ~clk_i;

  record_deque_with_dump_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .action_i   (action_i),
    .rec_id_i   (rec_id_i),
    .rec_score_i(rec_score_i),
    .strobe_o   (strobe_o),
    .kind_o     (kind_o),
    .out_id_o   (out_id_o),
    .out_score_o(out_score_o),
    .last_o     (last_o)
  );

  logic [31:0] ring_id [DEPTH];
  logic [31:0] ring_score [DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_fill = 0;
  result_t     ring_out[$];
  result_t     due_results[$];
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  function automatic void ring_apply(input logic [2:0] act, input logic [31:0] id,
                                     input logic [31:0] score);
    int unsigned slot;
    ring_out.delete();
    case (act)
      rdq_pkg::ACT_PUSH_FRONT, rdq_pkg::ACT_PUSH_BACK: begin
        if (ring_fill == DEPTH) begin
          ring_out.push_back('{kind: rdq_pkg::KIND_PUSH_FULL, id: '0, score: '0, last: 1'b1});
        end else begin
          if (act == rdq_pkg::ACT_PUSH_FRONT) begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            slot = ring_head;
          end else begin
            slot = (ring_head + ring_fill) % DEPTH;
          end
          ring_id[slot] = id;
          ring_score[slot] = score;
          ring_fill++;
        end
      end
      rdq_pkg::ACT_POP_FRONT, rdq_pkg::ACT_POP_BACK: begin
        if (ring_fill == 0) begin
          ring_out.push_back('{kind: rdq_pkg::KIND_POP_EMPTY, id: '0, score: '0, last: 1'b1});
        end else begin
          if (act == rdq_pkg::ACT_POP_FRONT) ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
        end
      end
      rdq_pkg::ACT_DUMP: begin
        if (ring_fill == 0) begin
          ring_out.push_back('{kind: rdq_pkg::KIND_DUMP_EMPTY, id: '0, score: '0, last: 1'b1});
        end else begin
          for (int unsigned i = 0; i < ring_fill; i++) begin
            slot = (ring_head + i) % DEPTH;
            ring_out.push_back('{kind: rdq_pkg::KIND_RECORD, id: ring_id[slot],
                                 score: ring_score[slot], last: (i + 1 == ring_fill)});
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor_b
    result_t want;
    if (rst_ni) begin
      if (strobe_o) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d id %h score %h last %b",
                   $time, kind_o, out_id_o, out_score_o, last_o);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_o));
          check_field("out_id", want.id, out_id_o);
          check_field("out_score", want.score, out_score_o);
          check_field("last", 32'(want.last), 32'(last_o));
        end
      end
      if (start_i && !busy_o) begin
        ring_apply(action_i, rec_id_i, rec_score_i);
        if (row_typed) begin
          due_results.push_back('{kind: row_kind, id: '0, score: '0, last: 1'b1});
        end else begin
          foreach (ring_out[k]) due_results.push_back(ring_out[k]);
        end
      end
      if (start_i && !busy_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic issue(input logic [2:0] act, input logic [31:0] id, input logic [31:0] score,
                       input bit typed, input rdq_pkg::kind_e kind, input bit allow_gap);
    bit took;
    if (allow_gap) begin
      while ($urandom_range(99) < 34) begin
        start_i <= 1'b0;
        action_i <= 3'($urandom);
        rec_id_i <= $urandom;
        rec_score_i <= $urandom;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    action_i <= act;
    rec_id_i <= id;
    rec_score_i <= score;
    row_typed <= typed;
    row_kind <= kind;
    do begin
      @(negedge clk_i);
      took = !busy_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_action(input int push_pct);
    int r;
    if ($urandom_range(99) < push_pct) begin
      return $urandom_range(1) ? rdq_pkg::ACT_PUSH_BACK : rdq_pkg::ACT_PUSH_FRONT;
    end
    r = $urandom_range(99);
    if (r < 4) return 3'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
    if (r < 22) return rdq_pkg::ACT_DUMP;
    return $urandom_range(1) ? rdq_pkg::ACT_POP_BACK : rdq_pkg::ACT_POP_FRONT;
  endfunction

  row_t directed_rows[] = '{
    '{rdq_pkg::ACT_POP_FRONT,  32'h0,         32'h0,         1'b1, rdq_pkg::KIND_POP_EMPTY},
    '{rdq_pkg::ACT_POP_BACK,   32'h0,         32'h0,         1'b1, rdq_pkg::KIND_POP_EMPTY},
    '{rdq_pkg::ACT_DUMP,       32'h0,         32'h0,         1'b1, rdq_pkg::KIND_DUMP_EMPTY},
    '{ACT_UNUSED_LO,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, rdq_pkg::KIND_RECORD},
    '{ACT_UNUSED_HI,           32'h8000_0000, 32'h7FFF_FFFF, 1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_PUSH_BACK,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_PUSH_BACK,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_DUMP,       32'h0,         32'h0,         1'b0, rdq_pkg::KIND_RECORD},
    '{ACT_UNUSED_LO,           32'h1234_5678, 32'h9ABC_DEF0, 1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_POP_FRONT,  32'h0,         32'h0,         1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_POP_BACK,   32'h0,         32'h0,         1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_DUMP,       32'h0,         32'h0,         1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_POP_BACK,   32'h0,         32'h0,         1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_POP_FRONT,  32'h0,         32'h0,         1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_DUMP,       32'h0,         32'h0,         1'b1, rdq_pkg::KIND_DUMP_EMPTY},
    '{rdq_pkg::ACT_POP_BACK,   32'h0,         32'h0,         1'b1, rdq_pkg::KIND_POP_EMPTY},
    '{rdq_pkg::ACT_PUSH_BACK,  32'h1234_5678, 32'h9ABC_DEF0, 1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_POP_FRONT,  32'h0,         32'h0,         1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_PUSH_FRONT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_POP_BACK,   32'h0,         32'h0,         1'b0, rdq_pkg::KIND_RECORD},
    '{rdq_pkg::ACT_DUMP,       32'h0,         32'h0,         1'b1, rdq_pkg::KIND_DUMP_EMPTY}
  };

  initial begin
    int n;
    int push_pct;
    int burst;
    logic [2:0] act;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      issue(directed_rows[r].act, directed_rows[r].id, directed_rows[r].score,
            directed_rows[r].typed, directed_rows[r].kind, 1'b1);
    end

    // Fill the ring to capacity from both ends, overflow it, dump it, then drain it.
    for (int i = 0; i < DEPTH; i++) begin
      issue($urandom_range(1) ? rdq_pkg::ACT_PUSH_BACK : rdq_pkg::ACT_PUSH_FRONT,
            pick_word(), pick_word(), 1'b0, rdq_pkg::KIND_RECORD, 1'b1);
    end
    issue(rdq_pkg::ACT_PUSH_FRONT, pick_word(), pick_word(), 1'b1,
          rdq_pkg::KIND_PUSH_FULL, 1'b1);
    issue(rdq_pkg::ACT_PUSH_BACK, pick_word(), pick_word(), 1'b1,
          rdq_pkg::KIND_PUSH_FULL, 1'b1);
    issue(rdq_pkg::ACT_DUMP, pick_word(), pick_word(), 1'b0, rdq_pkg::KIND_RECORD, 1'b1);
    for (int i = 0; i < DEPTH; i++) begin
      issue($urandom_range(1) ? rdq_pkg::ACT_POP_BACK : rdq_pkg::ACT_POP_FRONT,
            pick_word(), pick_word(), 1'b0, rdq_pkg::KIND_RECORD, 1'b1);
    end
    issue(rdq_pkg::ACT_POP_FRONT, pick_word(), pick_word(), 1'b1,
          rdq_pkg::KIND_POP_EMPTY, 1'b1);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      case ($urandom_range(2))
        0: push_pct = 80;
        1: push_pct = 30;
        default: push_pct = 50;
      endcase
      burst = $urandom_range(40, 8);
      for (int i = 0; i < burst && n < RANDOM_ITEMS; i++) begin
        act = pick_action(push_pct);
        issue(act, pick_word(), pick_word(), 1'b0, rdq_pkg::KIND_RECORD,
              !(n >= 60 && n < 120));
        if (act <= rdq_pkg::ACT_DUMP) n++;
      end
    end

    start_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
